// ===== hdl/cgcc_pkg.sv =====
`default_nettype none

package cgcc_pkg;

    localparam int MAX_VERTICES_DEFAULT = 64;
    localparam int VERTEX_COUNT_RESET   = 64;

    localparam int ACTION_W = 2;
    localparam int NODE_W   = 7;
    localparam int COUNT_W  = 7;
    localparam int ANSWER_W = 6;

    localparam logic [ACTION_W-1:0] ACT_ADD_EDGE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_COUNT    = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR    = 2'd2;

    typedef struct packed {
        logic capture;
        logic clear_adj;
        logic write_a;
        logic write_b;
        logic init_walk;
        logic start_push;
        logic start_skip;
        logic pop;
        logic read_row;
        logic scan_rst;
        logic scan_step;
        logic load_result;
    } cgcc_cmd_t;

    typedef struct packed {
        logic edge_ok;
        logic start_done;
        logic start_unvisited;
        logic stack_empty;
        logic scan_last;
        logic out_free;
    } cgcc_sts_t;

endpackage

`default_nettype wire

// ===== hdl/cgcc_ctrl.sv =====
`default_nettype none

module cgcc_ctrl (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [cgcc_pkg::ACTION_W-1:0]      action,
    input  wire cgcc_pkg::cgcc_sts_t                sts,
    output cgcc_pkg::cgcc_cmd_t                     cmd
);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_EDGE_A = 8'b0000_0010,
        ST_EDGE_B = 8'b0000_0100,
        ST_START  = 8'b0000_1000,
        ST_POP    = 8'b0001_0000,
        ST_ROW    = 8'b0010_0000,
        ST_SCAN   = 8'b0100_0000,
        ST_DONE   = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        s_tready   = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    unique case (action)
                        cgcc_pkg::ACT_ADD_EDGE: begin
                            if (sts.edge_ok) begin
                                cmd.capture = 1'b1;
                                state_next  = ST_EDGE_A;
                            end
                        end
                        cgcc_pkg::ACT_COUNT: begin
                            cmd.init_walk = 1'b1;
                            state_next    = ST_START;
                        end
                        cgcc_pkg::ACT_CLEAR: begin
                            cmd.clear_adj = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            ST_EDGE_A: begin
                cmd.write_a = 1'b1;
                state_next  = ST_EDGE_B;
            end
            ST_EDGE_B: begin
                cmd.write_b = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_START: begin
                if (sts.start_done) begin
                    state_next = ST_DONE;
                end else if (sts.start_unvisited) begin
                    cmd.start_push = 1'b1;
                    state_next     = ST_POP;
                end else begin
                    cmd.start_skip = 1'b1;
                end
            end
            ST_POP: begin
                if (sts.stack_empty) begin
                    state_next = ST_START;
                end else begin
                    cmd.pop    = 1'b1;
                    state_next = ST_ROW;
                end
            end
            ST_ROW: begin
                cmd.read_row = 1'b1;
                cmd.scan_rst = 1'b1;
                state_next   = ST_SCAN;
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last) begin
                    state_next = ST_POP;
                end
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.load_result = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/cgcc_datapath.sv =====
`default_nettype none

module cgcc_datapath #(
    parameter int MAX_VERTICES = cgcc_pkg::MAX_VERTICES_DEFAULT
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_valid,
    input  wire logic [cgcc_pkg::NODE_W-1:0]        cfg_data,
    input  wire logic [cgcc_pkg::NODE_W-1:0]        node_a,
    input  wire logic [cgcc_pkg::NODE_W-1:0]        node_b,
    input  wire cgcc_pkg::cgcc_cmd_t                cmd,
    output cgcc_pkg::cgcc_sts_t                     sts,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [15:0]                             m_tdata
);

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int NW = $clog2(MAX_VERTICES + 1);
    localparam int RESET_N = (cgcc_pkg::VERTEX_COUNT_RESET > MAX_VERTICES) ?
                             MAX_VERTICES : cgcc_pkg::VERTEX_COUNT_RESET;

    logic [NW-1:0]                  n_reg;
    logic [NW-1:0]                  n_next;

    logic [VW-1:0]                  a_idx_reg;
    logic [VW-1:0]                  b_idx_reg;

    logic [MAX_VERTICES-1:0]        adj_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0]        row_valid_reg;
    logic [MAX_VERTICES-1:0]        adj_row_reg;
    logic                           row_live_reg;
    logic [MAX_VERTICES-1:0]        row_eff;

    logic [VW-1:0]                  walk_stack [MAX_VERTICES];
    logic [NW-1:0]                  depth_reg;
    logic [NW-1:0]                  depth_dec;
    logic [VW-1:0]                  top_reg;

    logic [MAX_VERTICES-1:0]        unvisited_reg;
    logic [MAX_VERTICES-1:0]        active_mask;
    logic [NW-1:0]                  start_reg;
    logic [VW-1:0]                  v_reg;
    logic [NW-1:0]                  tally_reg;

    logic                           wr_en;
    logic [VW-1:0]                  wr_row;
    logic [VW-1:0]                  wr_col;
    logic                           hit;
    logic                           push_en;
    logic [VW-1:0]                  push_data;

    logic                           m_valid_reg;
    logic [cgcc_pkg::COUNT_W-1:0]   comp_reg;
    logic [cgcc_pkg::ANSWER_W-1:0]  ans_reg;

    // effective vertex count
    always_comb begin
        if (cfg_data == '0) begin
            n_next = NW'(1);
        end else if (32'(cfg_data) > 32'(MAX_VERTICES)) begin
            n_next = NW'(MAX_VERTICES);
        end else begin
            n_next = NW'(cfg_data);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg <= NW'(RESET_N);
        end else if (cfg_valid) begin
            n_reg <= n_next;
        end
    end

    // endpoint check and capture
    assign sts.edge_ok = (node_a != '0) && (32'(node_a) <= 32'(n_reg)) &&
                         (node_b != '0) && (32'(node_b) <= 32'(n_reg));

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            a_idx_reg <= VW'(node_a - 7'd1);
            b_idx_reg <= VW'(node_b - 7'd1);
        end
    end

    // adjacency matrix, one row per entry, row valid bits in flops
    assign wr_en  = cmd.write_a | cmd.write_b;
    assign wr_row = cmd.write_a ? a_idx_reg : b_idx_reg;
    assign wr_col = cmd.write_a ? b_idx_reg : a_idx_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            if (row_valid_reg[wr_row]) begin
                adj_mem[wr_row][wr_col] <= 1'b1;
            end else begin
                adj_mem[wr_row] <= MAX_VERTICES'(1) << wr_col;
            end
        end
        if (cmd.read_row) begin
            adj_row_reg <= adj_mem[top_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
            row_live_reg  <= 1'b0;
        end else begin
            if (cmd.clear_adj) begin
                row_valid_reg <= '0;
            end else if (wr_en) begin
                row_valid_reg[wr_row] <= 1'b1;
            end
            if (cmd.read_row) begin
                row_live_reg <= row_valid_reg[top_reg];
            end
        end
    end

    assign row_eff = row_live_reg ? adj_row_reg : '0;

    // walk stack
    assign hit       = unvisited_reg[v_reg] & ~row_eff[v_reg];
    assign push_en   = cmd.start_push | (cmd.scan_step & hit);
    assign push_data = cmd.start_push ? start_reg[VW-1:0] : v_reg;
    assign depth_dec = depth_reg - NW'(1);

    always_ff @(posedge aclk) begin
        if (push_en) begin
            walk_stack[depth_reg[VW-1:0]] <= push_data;
        end
        if (cmd.pop) begin
            top_reg <= walk_stack[depth_dec[VW-1:0]];
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_VERTICES; i++) begin
            active_mask[i] = (32'(i) < 32'(n_reg));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg     <= '0;
            unvisited_reg <= '0;
            start_reg     <= '0;
            v_reg         <= '0;
            tally_reg     <= '0;
        end else begin
            if (cmd.init_walk) begin
                depth_reg     <= '0;
                unvisited_reg <= active_mask;
                start_reg     <= '0;
                tally_reg     <= '0;
            end else begin
                if (push_en) begin
                    depth_reg <= depth_reg + NW'(1);
                end else if (cmd.pop) begin
                    depth_reg <= depth_dec;
                end
                if (cmd.start_push) begin
                    unvisited_reg[start_reg[VW-1:0]] <= 1'b0;
                    tally_reg <= tally_reg + NW'(1);
                end else if (cmd.scan_step && hit) begin
                    unvisited_reg[v_reg] <= 1'b0;
                end
                if (cmd.start_push || cmd.start_skip) begin
                    start_reg <= start_reg + NW'(1);
                end
            end
            if (cmd.scan_rst) begin
                v_reg <= '0;
            end else if (cmd.scan_step) begin
                v_reg <= v_reg + VW'(1);
            end
        end
    end

    assign sts.start_done      = (start_reg == n_reg);
    assign sts.start_unvisited = unvisited_reg[start_reg[VW-1:0]];
    assign sts.stack_empty     = (depth_reg == '0);
    assign sts.scan_last       = (NW'(v_reg) == (n_reg - NW'(1)));

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_result) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_result) begin
            comp_reg <= cgcc_pkg::COUNT_W'(tally_reg);
            ans_reg  <= cgcc_pkg::ANSWER_W'(tally_reg - NW'(1));
        end
    end

    assign sts.out_free = !m_valid_reg || m_tready;
    assign m_tvalid     = m_valid_reg;
    assign m_tdata      = {3'b000, ans_reg, comp_reg};

endmodule

`default_nettype wire

// ===== hdl/complement_graph_component_count_core.sv =====
// Counts connected components of the complement of a loaded undirected graph.
// Input stream: s_tuser carries the action (add edge, count, clear), s_tdata
// carries the two endpoints of an edge. Result stream: one transaction per
// count action with the component count and that count minus one.
// Config channel: cfg_valid/cfg_ready/cfg_data writes the vertex count in use;
// write it only while the block is idle.
// An add-edge transaction with valid endpoints occupies the input through the
// accept and one row write per endpoint; a clear is done in the accept itself.
// The run time of a count for n vertices in use is set by the row scan, which
// tests one adjacency bit per cycle for each vertex popped off the walk stack.
// s_tready is high only while no action is in progress.
// The result sits in an output register; while the receiver stalls, add-edge
// and clear actions are still accepted, and a following count finishes its
// walk and then waits for the register to drain.
// Reset clears the adjacency matrix (row valid bits), the walk state, the
// output valid, and sets the vertex count to 64 (or the maximum if smaller).
`default_nettype none

module complement_graph_component_count_core #(
    parameter int MAX_VERTICES = cgcc_pkg::MAX_VERTICES_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // node_a [6:0], node_b [13:7]
    input  wire logic [1:0]  s_tuser,   // action [1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // components [6:0], answer [12:7]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [6:0]  cfg_data   // vertex_count [6:0]
);

    cgcc_pkg::cgcc_cmd_t cmd;
    cgcc_pkg::cgcc_sts_t sts;

    assign cfg_ready = 1'b1;

    cgcc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .action   (s_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    cgcc_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .node_a    (s_tdata[6:0]),
        .node_b    (s_tdata[13:7]),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

// ===== test/tb_complement_graph_component_count_core.sv =====
`default_nettype none

module tb_complement_graph_component_count_core;

    localparam logic [cgcc_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int MAXV = cgcc_pkg::MAX_VERTICES_DEFAULT;
    localparam int RANDOM_ITEMS = 430;

    typedef struct packed {
        logic [cgcc_pkg::ACTION_W-1:0] action;
        logic [cgcc_pkg::NODE_W-1:0]   node_a;
        logic [cgcc_pkg::NODE_W-1:0]   node_b;
    } graph_op_t;

    typedef struct packed {
        logic [cgcc_pkg::COUNT_W-1:0]  components;
        logic [cgcc_pkg::ANSWER_W-1:0] answer;
    } tally_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;   // node_a [6:0], node_b [13:7]
    logic [1:0]  s_tuser = '0;   // action [1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;        // components [6:0], answer [12:7]
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [6:0]  cfg_data = '0;  // vertex_count [6:0]

    complement_graph_component_count_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // mirror of the block state
    logic [MAXV-1:0] graph_rows [MAXV];
    logic [6:0]      vertex_reg = 7'd64;

    graph_op_t pending_items [$];
    tally_t    expected_tallies [$];
    graph_op_t cur_op;

    int  mismatches = 0;
    int  queued_ops = 0;
    bit  idle_on = 1'b0;
    int  hold_epoch = 0;
    int  hold_seen = 0;
    int  src_gap = 0;
    bit  src_busy;
    bit  src_next;
    int  sink_gap = 0;
    tally_t got_tally;
    tally_t want_tally;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int active_count(input logic [6:0] vc);
        if (vc == 0) return 1;
        if (vc > MAXV) return MAXV;
        return int'(vc);
    endfunction

    function automatic int complement_components(input int n);
        logic [MAXV-1:0] open_set;
        int walk [$];
        int tally;
        int u;
        open_set = '0;
        for (int v = 0; v < n; v++) open_set[v] = 1'b1;
        tally = 0;
        for (int s = 0; s < n; s++) begin
            if (open_set[s]) begin
                tally++;
                open_set[s] = 1'b0;
                walk.insert(walk.size(), s);
                while (walk.size() > 0) begin
                    u = walk.pop_back();
                    for (int v = 0; v < n; v++) begin
                        if (open_set[v] && !graph_rows[u][v]) begin
                            open_set[v] = 1'b0;
                            walk.insert(walk.size(), v);
                        end
                    end
                end
            end
        end
        return tally;
    endfunction

    task automatic apply_op(input graph_op_t op);
        int n;
        int c;
        tally_t t;
        n = active_count(vertex_reg);
        case (op.action)
            cgcc_pkg::ACT_ADD_EDGE: begin
                if (op.node_a >= 1 && op.node_a <= n && op.node_b >= 1 && op.node_b <= n) begin
                    graph_rows[op.node_a - 1][op.node_b - 1] = 1'b1;
                    graph_rows[op.node_b - 1][op.node_a - 1] = 1'b1;
                end
            end
            cgcc_pkg::ACT_COUNT: begin
                c = complement_components(n);
                t.components = c[cgcc_pkg::COUNT_W-1:0];
                t.answer = cgcc_pkg::ANSWER_W'(c - 1);
                expected_tallies.insert(expected_tallies.size(), t);
            end
            cgcc_pkg::ACT_CLEAR: begin
                for (int i = 0; i < MAXV; i++) graph_rows[i] = '0;
            end
            default: begin
            end
        endcase
    endtask

    function automatic int pick_gap(input bit enabled);
        int r;
        if (!enabled) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // input side driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_gap = 0;
        end else begin
            src_busy = s_tvalid && !s_tready;
            src_next = 1'b0;
            if (s_tvalid && s_tready) apply_op(cur_op);
            if (!src_busy) begin
                if (src_gap > 0) begin
                    src_gap--;
                end else if (pending_items.size() > 0) begin
                    cur_op = pending_items.pop_front();
                    s_tuser <= cur_op.action;
                    s_tdata <= {2'b00, cur_op.node_b, cur_op.node_a};
                    src_next = 1'b1;
                    src_gap = pick_gap(idle_on);
                end
            end
            s_tvalid <= src_busy || src_next;
        end
    end

    // result side monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            sink_gap = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_tally.components = m_tdata[6:0];
                got_tally.answer = m_tdata[12:7];
                if (expected_tallies.size() == 0) begin
                    $display("%0t: unexpected transaction, got components %0d answer %0d",
                             $time, got_tally.components, got_tally.answer);
                    mismatches++;
                end else begin
                    want_tally = expected_tallies.pop_front();
                    if (got_tally.components !== want_tally.components) begin
                        $display("%0t: components expected %0d got %0d",
                                 $time, want_tally.components, got_tally.components);
                        mismatches++;
                    end
                    if (got_tally.answer !== want_tally.answer) begin
                        $display("%0t: answer expected %0d got %0d",
                                 $time, want_tally.answer, got_tally.answer);
                        mismatches++;
                    end
                end
            end
            if (hold_epoch != hold_seen) begin
                hold_seen = hold_epoch;
                sink_gap = 400;
            end
            if (sink_gap > 0) begin
                sink_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (idle_on && $urandom_range(0, 4) == 0) sink_gap = pick_gap(1'b1);
            end
        end
    end

    task automatic push_op(input logic [cgcc_pkg::ACTION_W-1:0] action, input int a,
                           input int b);
        graph_op_t op;
        op.action = action;
        op.node_a = cgcc_pkg::NODE_W'(a);
        op.node_b = cgcc_pkg::NODE_W'(b);
        pending_items.insert(pending_items.size(), op);
        queued_ops++;
    endtask

    task automatic wait_quiet();
        do @(negedge aclk);
        while (pending_items.size() > 0 || s_tvalid || expected_tallies.size() > 0);
        repeat (20) @(negedge aclk);
    endtask

    task automatic write_vertex_count(input logic [6:0] v);
        @(posedge aclk);
        cfg_data <= v;
        cfg_valid <= 1'b1;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        vertex_reg = v;
        @(negedge aclk);
    endtask

    // partition the vertices and queue most pairs across groups (random edges above
    // 16 vertices), so the complement tends to one component per group; some noise on top
    task automatic random_phase();
        int r;
        int n;
        int groups;
        int tmp;
        int k;
        int group_of [MAXV];
        int ea [$];
        int eb [$];
        logic [6:0] vc;
        logic [6:0] odd_counts [6] = '{7'd0, 7'd1, 7'd64, 7'd65, 7'd100, 7'd127};
        r = $urandom_range(0, 99);
        if (r < 6) vc = odd_counts[$urandom_range(0, 5)];
        else if (r < 20) vc = 7'($urandom_range(11, 14));
        else vc = 7'($urandom_range(2, 10));
        write_vertex_count(vc);
        idle_on = ($urandom_range(0, 3) != 0);
        n = active_count(vc);
        groups = $urandom_range(1, n);
        for (int i = 0; i < n; i++) group_of[i] = $urandom_range(0, groups - 1);
        if (n <= 16) begin
            for (int i = 0; i < n; i++) begin
                for (int j = i + 1; j < n; j++) begin
                    if (group_of[i] != group_of[j]) begin
                        ea.insert(ea.size(), i + 1);
                        eb.insert(eb.size(), j + 1);
                    end
                end
            end
        end else begin
            for (int i = 0; i < 40; i++) begin
                ea.insert(ea.size(), $urandom_range(1, n));
                eb.insert(eb.size(), $urandom_range(1, n));
            end
        end
        for (int i = ea.size() - 1; i > 0; i--) begin
            k = $urandom_range(0, i);
            tmp = ea[i]; ea[i] = ea[k]; ea[k] = tmp;
            tmp = eb[i]; eb[i] = eb[k]; eb[k] = tmp;
        end
        push_op(cgcc_pkg::ACT_CLEAR, $urandom_range(0, 127), $urandom_range(0, 127));
        for (int i = 0; i < ea.size(); i++) begin
            if ($urandom_range(0, 9) != 0) begin
                if ($urandom_range(0, 1)) push_op(cgcc_pkg::ACT_ADD_EDGE, ea[i], eb[i]);
                else push_op(cgcc_pkg::ACT_ADD_EDGE, eb[i], ea[i]);
            end
            r = $urandom_range(0, 99);
            if (r < 3)
                push_op(cgcc_pkg::ACT_ADD_EDGE, $urandom_range(0, 127), $urandom_range(0, 127));
            else if (r < 5)
                push_op(ACT_UNUSED, $urandom_range(0, 127), $urandom_range(0, 127));
            else if (r < 7)
                push_op(cgcc_pkg::ACT_ADD_EDGE, ea[i], eb[i]);
            else if (r < 9)
                push_op(cgcc_pkg::ACT_ADD_EDGE, $urandom_range(1, n), $urandom_range(1, n));
            else if (r < 10)
                push_op(cgcc_pkg::ACT_CLEAR, $urandom_range(0, 127), $urandom_range(0, 127));
            if ($urandom_range(0, 99) < 8)
                push_op(cgcc_pkg::ACT_COUNT, $urandom_range(0, 127), $urandom_range(0, 127));
        end
        push_op(cgcc_pkg::ACT_COUNT, $urandom_range(0, 127), $urandom_range(0, 127));
        wait_quiet();
    endtask

    initial begin
        for (int i = 0; i < MAXV; i++) graph_rows[i] = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset vertex count, extremes of the endpoints
        push_op(cgcc_pkg::ACT_COUNT, 0, 0);
        push_op(cgcc_pkg::ACT_ADD_EDGE, 1, 64);
        push_op(cgcc_pkg::ACT_ADD_EDGE, 64, 1);
        push_op(cgcc_pkg::ACT_ADD_EDGE, 5, 5);
        push_op(cgcc_pkg::ACT_ADD_EDGE, 0, 3);
        push_op(cgcc_pkg::ACT_ADD_EDGE, 3, 65);
        push_op(cgcc_pkg::ACT_ADD_EDGE, 127, 127);
        push_op(ACT_UNUSED, 127, 127);
        push_op(cgcc_pkg::ACT_ADD_EDGE, 2, 3);
        push_op(cgcc_pkg::ACT_COUNT, 0, 0);
        push_op(cgcc_pkg::ACT_CLEAR, 0, 0);
        push_op(cgcc_pkg::ACT_COUNT, 127, 127);
        wait_quiet();

        write_vertex_count(7'd1);
        push_op(cgcc_pkg::ACT_COUNT, 0, 0);
        push_op(cgcc_pkg::ACT_ADD_EDGE, 1, 1);
        push_op(cgcc_pkg::ACT_ADD_EDGE, 1, 2);
        push_op(cgcc_pkg::ACT_COUNT, 0, 0);
        wait_quiet();

        // zero acts as one vertex
        write_vertex_count(7'd0);
        push_op(cgcc_pkg::ACT_ADD_EDGE, 1, 1);
        push_op(cgcc_pkg::ACT_COUNT, 0, 0);
        wait_quiet();

        write_vertex_count(7'd2);
        push_op(cgcc_pkg::ACT_ADD_EDGE, 1, 2);
        push_op(cgcc_pkg::ACT_COUNT, 0, 0);
        wait_quiet();

        // above the maximum acts as the maximum
        write_vertex_count(7'd127);
        push_op(cgcc_pkg::ACT_ADD_EDGE, 64, 63);
        push_op(cgcc_pkg::ACT_COUNT, 0, 0);
        wait_quiet();

        // long receiver hold-off while counts keep coming
        write_vertex_count(7'd4);
        idle_on = 1'b0;
        push_op(cgcc_pkg::ACT_CLEAR, 0, 0);
        push_op(cgcc_pkg::ACT_ADD_EDGE, 1, 3);
        push_op(cgcc_pkg::ACT_ADD_EDGE, 1, 4);
        push_op(cgcc_pkg::ACT_ADD_EDGE, 2, 3);
        push_op(cgcc_pkg::ACT_ADD_EDGE, 2, 4);
        hold_epoch++;
        for (int i = 0; i < 6; i++) begin
            push_op(cgcc_pkg::ACT_COUNT, 0, 0);
            push_op(cgcc_pkg::ACT_ADD_EDGE, 4, 1);
        end
        push_op(cgcc_pkg::ACT_COUNT, 0, 0);
        wait_quiet();

        queued_ops = 0;
        while (queued_ops < RANDOM_ITEMS) random_phase();

        wait_quiet();
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #100000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
